/* hw/rtl/hsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl pixel conversion package
// shared widths, hue constants, the hue ramp weight function and the
// stage enable bundle of the conversion pipeline
// ----------------------------------------------------------------------------
package hsl_pkg;

   // field widths
   localparam int HUE_W       = 12;
   localparam int FRAC_IN_W   = 13;
   localparam int CHAN_W      = 8;

   // default fraction scale, 2^12 means 1.0
   localparam int FRAC_BITS_DEFAULT = 12;

   // hue ramp weight, 0..600
   localparam int T_W = 10;

   // quotient before the final divide by five
   localparam int Q_W = 11;

   // floor(q / 5) as (q * DIV5_MUL) >> DIV5_SHIFT, exact for q below 2^18
   localparam int DIV5_W     = 16;
   localparam int DIV5_SHIFT = 18;
   localparam logic [DIV5_W-1:0] DIV5_MUL = 16'd52429;

   // hue in tenths of a degree
   localparam logic [HUE_W-1:0] HUE_FULL  = 12'd3600;
   localparam logic [HUE_W-1:0] HUE_THIRD = 12'd1200;
   localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 12'd2400;
   localparam logic [HUE_W-1:0] HUE_SIXTH = 12'd600;
   localparam logic [HUE_W-1:0] HUE_HALF  = 12'd1800;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // pipeline depth
   localparam int STAGES = 7;

   // advance strobes of the per-channel stages
   typedef struct packed {
      logic s4;
      logic s5;
      logic s6;
      logic s7;
   } stage_en_type;

   // weight of (m2 - m1) in the ramp: result = 600*m1 + span*t
   function automatic logic [T_W-1:0] hue_ramp_t(input logic [HUE_W-1:0] h);
      logic [HUE_W-1:0] fall;
      logic [T_W-1:0]   t;
      fall = HUE_TWO_THIRDS - h;
      if (h < HUE_SIXTH) begin
         t = h[T_W-1:0];
      end else if (h < HUE_HALF) begin
         t = HUE_SIXTH[T_W-1:0];
      end else if (h < HUE_TWO_THIRDS) begin
         t = fall[T_W-1:0];
      end else begin
         t = '0;
      end
      return t;
   endfunction

endpackage

/* hw/rtl/hsl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl request channel
// valid/ready channel carrying one hsl color plus opacity
// ----------------------------------------------------------------------------
interface hsl_req_if;
   import hsl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [HUE_W-1:0]     hue_tenths;
   logic [FRAC_IN_W-1:0] saturation;
   logic [FRAC_IN_W-1:0] lightness;
   logic [FRAC_IN_W-1:0] opacity;

   modport source (
      output valid, hue_tenths, saturation, lightness, opacity,
      input  ready
   );

   modport sink (
      input  valid, hue_tenths, saturation, lightness, opacity,
      output ready
   );

endinterface

/* hw/rtl/hsl_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba response channel
// valid/ready channel carrying the four color bytes
// ----------------------------------------------------------------------------
interface hsl_rsp_if;
   import hsl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha_byte;

   modport source (
      output valid, red, green, blue, alpha_byte,
      input  ready
   );

   modport sink (
      input  valid, red, green, blue, alpha_byte,
      output ready
   );

endinterface

/* hw/rtl/hsl_chan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl color channel back end
// ramp value 600*m1 + span*t, scale by 255/(600*one^2), round and clamp,
// over stages four to seven
// ----------------------------------------------------------------------------
module hsl_chan #(
   parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  hsl_pkg::stage_en_type           stage_en,
   input  logic [2*FRAC_BITS:0]            m1,
   input  logic [2*FRAC_BITS:0]            span,
   input  logic [hsl_pkg::T_W-1:0]         ramp_t,
   output logic [hsl_pkg::CHAN_W-1:0]      chan_val
);
   import hsl_pkg::*;

   localparam int SW = 2 * FRAC_BITS + 1;          // m1, span
   localparam int PW = SW + T_W;                   // raw products
   localparam int NW = 2 * FRAC_BITS + 10;         // ramp numerator
   localparam int XW = 2 * FRAC_BITS + 14;         // rounded, scaled
   localparam int QSH = 2 * FRAC_BITS + 3;
   localparam int DW = Q_W + DIV5_W;
   // half of 5 * 2^(2F+3), the rounding offset
   localparam logic [XW-1:0] ROUND_OFS = XW'(5) << (2 * FRAC_BITS + 2);

   logic [PW-1:0]     base_full;
   logic [PW-1:0]     prod_full;
   logic [NW-1:0]     base_in,  base_ff;
   logic [NW-1:0]     prod_in,  prod_ff;
   logic [NW-1:0]     num_in,   num_ff;
   logic [XW-1:0]     scaled;
   logic [Q_W-1:0]    quot_in,  quot_ff;
   logic [DW-1:0]     div_full;
   logic [DW-DIV5_SHIFT-1:0] div_q;
   logic [CHAN_W-1:0] chan_in,  chan_ff;

   // stage 4: the two products
   assign base_full = PW'(m1) * PW'(HUE_SIXTH);
   assign prod_full = PW'(span) * PW'(ramp_t);
   assign base_in   = base_full[NW-1:0];
   assign prod_in   = prod_full[NW-1:0];

   // stage 5: ramp numerator
   assign num_in = base_ff + prod_ff;

   // stage 6: 17*n + offset, then drop 2F+3 bits
   assign scaled  = (XW'(num_ff) << 4) + XW'(num_ff) + ROUND_OFS;
   assign quot_in = scaled[XW-1:QSH];

   // stage 7: divide by five and clamp
   assign div_full = DW'(quot_ff) * DW'(DIV5_MUL);
   assign div_q    = div_full[DW-1:DIV5_SHIFT];
   assign chan_in  = (div_q > (DW-DIV5_SHIFT)'(CHAN_MAX)) ? CHAN_MAX : div_q[CHAN_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         base_ff <= base_in;
         prod_ff <= prod_in;
      end
      if (stage_en.s5) begin
         num_ff <= num_in;
      end
      if (stage_en.s6) begin
         quot_ff <= quot_in;
      end
      if (stage_en.s7) begin
         chan_ff <= chan_in;
      end
   end

   assign chan_val = chan_ff;

endmodule

/* hw/rtl/hsl_to_rgb_converter.sv */
`timescale 1ns / 1ps
// a request reaches the response channel through seven register stages
// throughput: one request per cycle while the response sink is ready, set by the seven-stage pipeline
// a stalled sink backs the pipeline up stage by stage; bubbles are squeezed out
// the widest step is the span x ramp weight multiply in stage four
// reset (synchronous) clears the stage valid bits only; data registers keep their value
// ----------------------------------------------------------------------------
// hsl to rgb converter
// css hsl() color to rgba bytes: clamp and hue wrap, m1/m2 build, three hue
// ramps, scale by 255 with rounding, opacity scaled and truncated
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
   parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   hsl_req_if.sink    req_bus,
   hsl_rsp_if.source  rsp_bus
);
   import hsl_pkg::*;

   // fraction widths
   localparam int FW = FRAC_BITS + 1;                         // 0..one
   localparam int CW = (FW > FRAC_IN_W) ? FW : FRAC_IN_W;     // clamp compare
   localparam int MW = 2 * FRAC_BITS + 2;                     // m build
   localparam int SW = 2 * FRAC_BITS + 1;                     // m1, span
   localparam int AW = FW + CHAN_W;                           // opacity * 255
   localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

   // saturate a request fraction at one
   function automatic logic [FW-1:0] clamp_frac(input logic [FRAC_IN_W-1:0] v);
      logic [CW-1:0] ext;
      logic [CW-1:0] sat;
      ext = CW'(v);
      sat = (ext > ONE_C) ? ONE_C : ext;
      return sat[FW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // valid bits and per-stage advance
   // a stage takes new data when it is empty or the next stage advances
   // ------------------------------------------------------------------
   logic [STAGES:1]   v_ff, v_in;
   logic [STAGES+1:1] en;
   stage_en_type      chan_en;

   always_comb begin
      en[STAGES+1] = rsp_bus.ready;
      for (int k = STAGES; k >= 1; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
      v_in[1] = req_bus.valid;
      for (int k = 2; k <= STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_bus.ready = en[1];

   assign chan_en.s4 = en[4];
   assign chan_en.s5 = en[5];
   assign chan_en.s6 = en[6];
   assign chan_en.s7 = en[7];

   // ------------------------------------------------------------------
   // stage 1: saturate fractions, wrap hue into 0..3599
   // ------------------------------------------------------------------
   logic [HUE_W-1:0] hue_in, hue_ff;
   logic [FW-1:0]    sat_in, sat_ff;
   logic [FW-1:0]    lit_in, lit_ff;
   logic [FW-1:0]    opa_in, opa_ff;

   assign hue_in = (req_bus.hue_tenths >= HUE_FULL) ? (req_bus.hue_tenths - HUE_FULL)
                                                    : req_bus.hue_tenths;
   assign sat_in = clamp_frac(req_bus.saturation);
   assign lit_in = clamp_frac(req_bus.lightness);
   assign opa_in = clamp_frac(req_bus.opacity);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         lit_ff <= lit_in;
         opa_ff <= opa_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: l*s product, hue offsets and ramp weights, opacity byte
   // ------------------------------------------------------------------
   logic [HUE_W:0]     hr_sum;
   logic [HUE_W-1:0]   hue_r, hue_b;
   logic [2*FW-1:0]    ls_in, ls_ff;
   logic [FW-1:0]      lit2_ff, sat2_ff;
   logic               low_in, low_ff;
   logic [T_W-1:0]     tr_in, tr2_ff, tg_in, tg2_ff, tb_in, tb2_ff;
   logic [AW-1:0]      opa_scaled;
   logic [CHAN_W-1:0]  alpha_in;
   logic [CHAN_W-1:0]  alpha_ff [2:STAGES];

   // red leads by a third, blue trails by a third, both wrapped
   assign hr_sum = {1'b0, hue_ff} + {1'b0, HUE_THIRD};
   assign hue_r  = (hr_sum >= {1'b0, HUE_FULL}) ? HUE_W'(hr_sum - {1'b0, HUE_FULL})
                                                : hr_sum[HUE_W-1:0];
   assign hue_b  = (hue_ff >= HUE_THIRD) ? (hue_ff - HUE_THIRD) : (hue_ff + HUE_TWO_THIRDS);

   assign tr_in  = hue_ramp_t(hue_r);
   assign tg_in  = hue_ramp_t(hue_ff);
   assign tb_in  = hue_ramp_t(hue_b);

   assign ls_in  = (2*FW)'(lit_ff) * (2*FW)'(sat_ff);
   // lightness at or below one half
   assign low_in = ((FW+1)'(lit_ff) << 1) <= ((FW+1)'(1) << FRAC_BITS);

   assign opa_scaled = (AW'(opa_ff) << CHAN_W) - AW'(opa_ff);
   assign alpha_in   = opa_scaled[FRAC_BITS+CHAN_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ls_ff       <= ls_in;
         lit2_ff     <= lit_ff;
         sat2_ff     <= sat_ff;
         low_ff      <= low_in;
         tr2_ff      <= tr_in;
         tg2_ff      <= tg_in;
         tb2_ff      <= tb_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: m2, m1 and span = m2 - m1, all at scale one^2
   // ------------------------------------------------------------------
   logic [MW-1:0]  m2_w, two_l_one, m1_w, span_w;
   logic [SW-1:0]  m1_ff, span_ff;
   logic [T_W-1:0] tr3_ff, tg3_ff, tb3_ff;

   assign two_l_one = MW'(lit2_ff) << (FRAC_BITS + 1);
   assign m2_w = low_ff ? (MW'(ls_ff) + (MW'(lit2_ff) << FRAC_BITS))
                        : ((MW'(lit2_ff) + MW'(sat2_ff)) << FRAC_BITS) - MW'(ls_ff);
   assign m1_w   = two_l_one - m2_w;
   assign span_w = m2_w - m1_w;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         m1_ff       <= m1_w[SW-1:0];
         span_ff     <= span_w[SW-1:0];
         tr3_ff      <= tr2_ff;
         tg3_ff      <= tg2_ff;
         tb3_ff      <= tb2_ff;
      end
   end

   // opacity byte rides along from stage 2 with the rest of the pipeline
   always_ff @(posedge clock) begin
      if (en[2]) begin
         alpha_ff[2] <= alpha_in;
      end
      for (int k = 3; k <= STAGES; k++) begin
         if (en[k]) begin
            alpha_ff[k] <= alpha_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // stages 4..7: one ramp / scale / round unit per color
   // ------------------------------------------------------------------
   logic [CHAN_W-1:0] red_w, green_w, blue_w;

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
      .clock    (clock),
      .stage_en (chan_en),
      .m1       (m1_ff),
      .span     (span_ff),
      .ramp_t   (tr3_ff),
      .chan_val (red_w)
   );

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
      .clock    (clock),
      .stage_en (chan_en),
      .m1       (m1_ff),
      .span     (span_ff),
      .ramp_t   (tg3_ff),
      .chan_val (green_w)
   );

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
      .clock    (clock),
      .stage_en (chan_en),
      .m1       (m1_ff),
      .span     (span_ff),
      .ramp_t   (tb3_ff),
      .chan_val (blue_w)
   );

   // response side, stage 7 registers drive the channel directly
   assign rsp_bus.valid      = v_ff[STAGES];
   assign rsp_bus.red        = red_w;
   assign rsp_bus.green      = green_w;
   assign rsp_bus.blue       = blue_w;
   assign rsp_bus.alpha_byte = alpha_ff[STAGES];

endmodule

/* hw/rtl/hsl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl converter port checker
// watches the request and response channels of the converter over time
// ----------------------------------------------------------------------------
module hsl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hsl_pkg::CHAN_W-1:0]  rsp_red,
   input logic [hsl_pkg::CHAN_W-1:0]  rsp_green,
   input logic [hsl_pkg::CHAN_W-1:0]  rsp_blue,
   input logic [hsl_pkg::CHAN_W-1:0]  rsp_alpha
);
   import hsl_pkg::*;

   // a waiting response is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a waiting response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha))
      else $error("response payload changed while stalled");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with no response waiting every stage can advance, so requests are taken
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output stage");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.red),
   .rsp_green (rsp_bus.green),
   .rsp_blue  (rsp_bus.blue),
   .rsp_alpha (rsp_bus.alpha_byte)
);
